[src/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock, masked during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/fpsc_pkg.sv]
// ----------------------------------------------------------------------------
// fpsc_pkg: shared types and constants
// Operation codes, status codes and the per-item result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpsc_pkg;

  typedef enum logic [2:0] {
    OP_MCRFS  = 3'd0,
    OP_MFFS   = 3'd1,
    OP_MTFSB0 = 3'd2,
    OP_MTFSB1 = 3'd3,
    OP_MTFSF  = 3'd4,
    OP_MTFSFI = 3'd5,
    OP_FCMPU  = 3'd6,
    OP_FCMPO  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_TRAP    = 2'd2
  } status_t;

  localparam logic [31:0] MFFS_HIGH  = 32'hFFF8_0000;
  localparam logic [31:0] FPCC_MASK  = 32'h0000_F800;
  localparam logic [3:0]  CR1_CLEAR  = 4'hE;
  localparam logic [31:0] MTFSF_BAD  = 32'h0201_0000;
  localparam logic [31:0] MTFSFI_BAD = 32'h007F_0800;

  localparam logic [3:0] CC_LT = 4'd8;
  localparam logic [3:0] CC_GT = 4'd4;
  localparam logic [3:0] CC_EQ = 4'd2;
  localparam logic [3:0] CC_UN = 4'd1;

  typedef struct packed {
    logic [31:0] cr_value;
    logic [31:0] fpscr_value;
    logic        fpr_write;
    logic [4:0]  fpr_index;
    logic [63:0] fpr_data;
    logic [1:0]  status;
  } result_t;

  function automatic logic [31:0] mcrfs_clear(input logic [2:0] fld);
    logic [31:0] m;
    unique case (fld)
      3'd0: m = 32'h9000_0000;
      3'd1: m = 32'h0F00_0000;
      3'd2: m = 32'h00F0_0000;
      3'd3: m = 32'h0008_0000;
      3'd5: m = 32'h0000_0100;
      default: m = 32'h0;
    endcase
    return m;
  endfunction

endpackage

[src/fpsc_in_if.sv]
// ----------------------------------------------------------------------------
// fpsc_in_if: instruction channel
// Valid/ready channel carrying one status or compare instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fpsc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] instr;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, func, instr, operand_a, operand_b, input ready);
  modport sink (input valid, func, instr, operand_a, operand_b, output ready);
endinterface

[src/fpsc_out_if.sv]
// ----------------------------------------------------------------------------
// fpsc_out_if: result channel
// Valid/ready channel carrying the register state after one instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fpsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cr_value;
  logic [31:0] fpscr_value;
  logic        fpr_write;
  logic [4:0]  fpr_index;
  logic [63:0] fpr_data;
  logic [1:0]  status;
  modport source (output valid, cr_value, fpscr_value, fpr_write, fpr_index,
                  fpr_data, status, input ready);
  modport sink (input valid, cr_value, fpscr_value, fpr_write, fpr_index,
                fpr_data, status, output ready);
endinterface

[src/fpsc_compare.sv]
// ----------------------------------------------------------------------------
// fpsc_compare: double compare on bit patterns
// Produces the LT/GT/EQ/UN code and a NaN flag for two doubles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpsc_compare (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        has_nan,
  output logic [3:0]  code
);
  logic        nan_a;
  logic        nan_b;
  logic [63:0] key_a;
  logic [63:0] key_b;

  assign nan_a = (&a[62:52]) && (|a[51:0]);
  assign nan_b = (&b[62:52]) && (|b[51:0]);
  assign has_nan = nan_a || nan_b;

  // map sign-magnitude onto an unsigned order
  assign key_a = a[63] ? ~a : {1'b1, a[62:0]};
  assign key_b = b[63] ? ~b : {1'b1, b[62:0]};

  always_comb begin
    priority if (has_nan) begin
      code = fpsc_pkg::CC_UN;
    end else if ((a[62:0] | b[62:0]) == 63'd0 || key_a == key_b) begin
      code = fpsc_pkg::CC_EQ;
    end else if (key_a < key_b) begin
      code = fpsc_pkg::CC_LT;
    end else begin
      code = fpsc_pkg::CC_GT;
    end
  end
endmodule

[src/fp_status_control_unit.sv]
// ----------------------------------------------------------------------------
// fp_status_control_unit: FP status and compare unit
// Holds FPSCR and CR and executes one status or compare instruction per item.
// ----------------------------------------------------------------------------
// Channel | Modport | Payload
// in_ch   | sink    | func, instr, operand_a, operand_b
// out_ch  | source  | cr_value, fpscr_value, fpr_write, fpr_index, fpr_data, status
//
// The result is registered and valid in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle unless out_ch stalls; decode, compare
//   and register update all settle between the input handshake and result register.
// Reset clears FPSCR, CR and the result valid flag.
// A stalled result holds; a new transaction is taken whenever the result
//   register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fp_status_control_unit (
  input logic clk,
  input logic rst,
  fpsc_in_if.sink    in_ch,
  fpsc_out_if.source out_ch
);
  logic [31:0] fp_status;
  logic [31:0] cond_reg;
  logic [31:0] fp_status_next;
  logic [31:0] cond_reg_next;
  logic        out_valid;
  fpsc_pkg::result_t res;
  fpsc_pkg::result_t res_next;

  logic        accept;
  logic [4:0]  rd, ra, rb;
  logic        rc;
  logic        has_nan;
  logic [3:0]  cmp_code;
  logic [31:0] fld_mask;
  logic [31:0] cr1_mask;

  assign rd = in_ch.instr[25:21];
  assign ra = in_ch.instr[20:16];
  assign rb = in_ch.instr[15:11];
  assign rc = in_ch.instr[0];
  assign cr1_mask = {4'h0, fpsc_pkg::CR1_CLEAR, 24'h0};

  // accept while the result slot is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  fpsc_compare u_cmp (
    .a       (in_ch.operand_a),
    .b       (in_ch.operand_b),
    .has_nan (has_nan),
    .code    (cmp_code)
  );

  // mtfsf field mask: expand FM bits to nibbles
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fld_mask[4*i +: 4] = {4{in_ch.instr[17+i]}};
    end
  end

  always_comb begin
    logic [2:0]  src_fld;
    logic [2:0]  dst_fld;
    logic [3:0]  nib;
    logic [2:0]  imm_fld;
    src_fld = ra[4:2];
    dst_fld = rd[4:2];
    nib = fp_status[(5'd28 - {src_fld, 2'b00}) +: 4];
    imm_fld = in_ch.instr[25:23];
    fp_status_next = fp_status;
    cond_reg_next  = cond_reg;
    res_next.fpr_write = 1'b0;
    res_next.fpr_index = 5'd0;
    res_next.fpr_data  = 64'd0;
    res_next.status    = fpsc_pkg::ST_OK;
    unique case (fpsc_pkg::op_t'(in_ch.func))
      fpsc_pkg::OP_MCRFS: begin
        if (rb != 5'd0 || ra[1:0] != 2'd0 || rd[1:0] != 2'd0) begin
          res_next.status = fpsc_pkg::ST_ILLEGAL;
        end else begin
          cond_reg_next[(5'd28 - {dst_fld, 2'b00}) +: 4] = nib;
          fp_status_next = fp_status & ~fpsc_pkg::mcrfs_clear(src_fld);
        end
      end
      fpsc_pkg::OP_MFFS: begin
        if (ra != 5'd0 || rb != 5'd0) begin
          res_next.status = fpsc_pkg::ST_ILLEGAL;
        end else begin
          res_next.fpr_write = 1'b1;
          res_next.fpr_index = rd;
          res_next.fpr_data  = {fpsc_pkg::MFFS_HIGH, fp_status};
          if (rc) cond_reg_next = cond_reg & ~cr1_mask;
        end
      end
      fpsc_pkg::OP_MTFSB0, fpsc_pkg::OP_MTFSB1: begin
        if (ra != 5'd0 || rb != 5'd0) begin
          res_next.status = fpsc_pkg::ST_ILLEGAL;
        end else begin
          fp_status_next[5'd31 - rd] = (in_ch.func == fpsc_pkg::OP_MTFSB1);
          if (rc) cond_reg_next = cond_reg & ~cr1_mask;
        end
      end
      fpsc_pkg::OP_MTFSF: begin
        if ((in_ch.instr & fpsc_pkg::MTFSF_BAD) != 32'd0) begin
          res_next.status = fpsc_pkg::ST_ILLEGAL;
        end else begin
          fp_status_next = (fp_status & ~fld_mask) | (in_ch.operand_b[31:0] & fld_mask);
          if (rc) cond_reg_next = cond_reg & ~cr1_mask;
        end
      end
      fpsc_pkg::OP_MTFSFI: begin
        if ((in_ch.instr & fpsc_pkg::MTFSFI_BAD) != 32'd0) begin
          res_next.status = fpsc_pkg::ST_ILLEGAL;
        end else begin
          fp_status_next[(5'd28 - {imm_fld, 2'b00}) +: 4] = in_ch.instr[15:12];
          if (rc) cond_reg_next = cond_reg & ~cr1_mask;
        end
      end
      fpsc_pkg::OP_FCMPU, fpsc_pkg::OP_FCMPO: begin
        if (rd[1:0] != 2'd0) begin
          res_next.status = fpsc_pkg::ST_ILLEGAL;
        end else if (has_nan && in_ch.func == fpsc_pkg::OP_FCMPO) begin
          res_next.status = fpsc_pkg::ST_TRAP;
        end else begin
          cond_reg_next[(5'd28 - {dst_fld, 2'b00}) +: 4] = cmp_code;
          fp_status_next = (fp_status & ~fpsc_pkg::FPCC_MASK) | {17'd0, cmp_code, 11'd0};
        end
      end
      default: begin
      end
    endcase
    res_next.cr_value    = cond_reg_next;
    res_next.fpscr_value = fp_status_next;
  end

  // advance architectural state and the result register on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      fp_status <= 32'd0;
      cond_reg  <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fp_status <= fp_status_next;
        cond_reg  <= cond_reg_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.cr_value    = res.cr_value;
  assign out_ch.fpscr_value = res.fpscr_value;
  assign out_ch.fpr_write   = res.fpr_write;
  assign out_ch.fpr_index   = res.fpr_index;
  assign out_ch.fpr_data    = res.fpr_data;
  assign out_ch.status      = res.status;

  `ASSERT_NEXT(a_fault_keeps_state, clk, rst,
    accept && res_next.status != fpsc_pkg::ST_OK,
    $stable(fp_status) && $stable(cond_reg))
  `ASSERT_IMPL(a_fpr_only_mffs, clk, rst,
    out_valid && out_ch.fpr_write, out_ch.status == fpsc_pkg::ST_OK)
  `ASSERT_NEXT(a_result_tracks_state, clk, rst,
    accept, out_ch.fpscr_value == fp_status && out_ch.cr_value == cond_reg)
endmodule

[verif/fp_status_control_unit_tb.sv]
// ----------------------------------------------------------------------------
// fp_status_control_unit_tb: self-checking bench for the FP status unit
// Drives status and compare instructions through the valid/ready channel,
// predicts CR, FPSCR, FPR write and status per transaction, and compares
// every result in order. Idling phases and a long result stall are included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fp_status_control_unit_tb;

  typedef struct {
    fpsc_pkg::op_t op;
    logic [31:0]   instr;
    logic [63:0]   opa;
    logic [63:0]   opb;
  } instr_item_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();

  fp_status_control_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // Predictor state: architectural FPSCR and CR as the block should hold them
  logic [31:0] model_fpscr;
  logic [31:0] model_cr;

  instr_item_t         pending_q[$];
  fpsc_pkg::result_t   expected_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off;               // forced receiver stall, in cycles
  bit long_stall_req;         // request one long receiver stall
  bit long_stall_taken;
  int mismatches     = 0;
  int cycles         = 0;

  function automatic logic [31:0] fld_mask(input logic [2:0] n);
    return 32'hF000_0000 >> (4 * n);
  endfunction

  function automatic logic [3:0] fld_get(input logic [2:0] n, input logic [31:0] w);
    return 4'((w << (4 * n)) >> 28);
  endfunction

  function automatic bit is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic [63:0] order_key(input logic [63:0] x);
    return x[63] ? ~x : (x | 64'h8000_0000_0000_0000);
  endfunction

  // Bit-pattern ordering of two non-NaN doubles; zeros of either sign are equal
  function automatic logic [3:0] cmp_code(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ka;
    logic [63:0] kb;
    if (((a | b) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0) return fpsc_pkg::CC_EQ;
    ka = order_key(a);
    kb = order_key(b);
    if (ka == kb) return fpsc_pkg::CC_EQ;
    return (ka < kb) ? fpsc_pkg::CC_LT : fpsc_pkg::CC_GT;
  endfunction

  function automatic logic [31:0] clear_bits(input logic [2:0] f);
    case (f)
      3'd0: return 32'h9000_0000;
      3'd1: return 32'h0F00_0000;
      3'd2: return 32'h00F0_0000;
      3'd3: return 32'h0008_0000;
      3'd5: return 32'h0000_0100;
      default: return 32'h0;
    endcase
  endfunction

  // Execute one instruction against the predictor state, return the result
  function automatic fpsc_pkg::result_t execute_instr(input instr_item_t it);
    fpsc_pkg::result_t r;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [7:0]  fm;
    logic [2:0]  f;
    logic [3:0]  code;
    logic [31:0] src;
    rd = it.instr[25:21];
    ra = it.instr[20:16];
    rb = it.instr[15:11];
    r  = '0;
    r.status = fpsc_pkg::ST_OK;
    case (it.op)
      fpsc_pkg::OP_MCRFS: begin
        if (rb != 0 || ra[1:0] != 0 || rd[1:0] != 0) r.status = fpsc_pkg::ST_ILLEGAL;
        else begin
          model_cr = (model_cr & ~fld_mask(rd[4:2]))
                   | ({28'd0, fld_get(ra[4:2], model_fpscr)} << (4 * (7 - rd[4:2])));
          model_fpscr &= ~clear_bits(ra[4:2]);
        end
      end
      fpsc_pkg::OP_MFFS, fpsc_pkg::OP_MTFSB0, fpsc_pkg::OP_MTFSB1: begin
        if (ra != 0 || rb != 0) r.status = fpsc_pkg::ST_ILLEGAL;
        else begin
          if (it.op == fpsc_pkg::OP_MFFS) begin
            r.fpr_write = 1'b1;
            r.fpr_index = rd;
            r.fpr_data  = {fpsc_pkg::MFFS_HIGH, model_fpscr};
          end else if (it.op == fpsc_pkg::OP_MTFSB0) model_fpscr[31 - rd] = 1'b0;
          else model_fpscr[31 - rd] = 1'b1;
          if (it.instr[0]) model_cr &= ~({28'd0, fpsc_pkg::CR1_CLEAR} << 24);
        end
      end
      fpsc_pkg::OP_MTFSF: begin
        if ((it.instr & fpsc_pkg::MTFSF_BAD) != 0) r.status = fpsc_pkg::ST_ILLEGAL;
        else begin
          fm  = it.instr[24:17];
          src = it.opb[31:0];
          for (int i = 0; i < 8; i++)
            if (fm[7 - i])
              model_fpscr = (model_fpscr & ~fld_mask(3'(i))) | (src & fld_mask(3'(i)));
          if (it.instr[0]) model_cr &= ~({28'd0, fpsc_pkg::CR1_CLEAR} << 24);
        end
      end
      fpsc_pkg::OP_MTFSFI: begin
        if ((it.instr & fpsc_pkg::MTFSFI_BAD) != 0) r.status = fpsc_pkg::ST_ILLEGAL;
        else begin
          f = it.instr[25:23];
          model_fpscr = (model_fpscr & ~fld_mask(f))
                      | ({28'd0, it.instr[15:12]} << (4 * (7 - f)));
          if (it.instr[0]) model_cr &= ~({28'd0, fpsc_pkg::CR1_CLEAR} << 24);
        end
      end
      default: begin
        if (rd[1:0] != 0) r.status = fpsc_pkg::ST_ILLEGAL;
        else if ((is_nan(it.opa) || is_nan(it.opb)) && it.op == fpsc_pkg::OP_FCMPO)
          r.status = fpsc_pkg::ST_TRAP;
        else begin
          code = (is_nan(it.opa) || is_nan(it.opb)) ? fpsc_pkg::CC_UN
                                                     : cmp_code(it.opa, it.opb);
          model_cr = (model_cr & ~fld_mask(rd[4:2]))
                   | ({28'd0, code} << (4 * (7 - rd[4:2])));
          model_fpscr = (model_fpscr & ~fpsc_pkg::FPCC_MASK) | ({28'd0, code} << 11);
        end
      end
    endcase
    r.cr_value    = model_cr;
    r.fpscr_value = model_fpscr;
    return r;
  endfunction

  // Driver: hold the current transaction until accepted, then advance
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= fpsc_pkg::OP_MCRFS;
      in_ch.instr     <= '0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(pending_q.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.func      <= pending_q[0].op;
          in_ch.instr     <= pending_q[0].instr;
          in_ch.operand_a <= pending_q[0].opa;
          in_ch.operand_b <= pending_q[0].opb;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Predict on acceptance so the expected order follows the handshake order
  always @(posedge clk) begin
    instr_item_t it;
    if (rst) begin
      model_fpscr = '0;
      model_cr    = '0;
    end else if (in_ch.valid && in_ch.ready) begin
      it.op    = fpsc_pkg::op_t'(in_ch.func);
      it.instr = in_ch.instr;
      it.opa   = in_ch.operand_a;
      it.opb   = in_ch.operand_b;
      expected_q.push_back(execute_instr(it));
    end
  end

  // Long hold-off counter: start once on request, then count down
  always @(posedge clk) begin
    if (rst) begin
      hold_off         <= 0;
      long_stall_taken <= 1'b0;
    end else if (long_stall_req && !long_stall_taken) begin
      hold_off         <= 300;
      long_stall_taken <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver stall generator
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0 || (long_stall_req && !long_stall_taken)) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    fpsc_pkg::result_t got;
    fpsc_pkg::result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.cr_value    = out_ch.cr_value;
      got.fpscr_value = out_ch.fpscr_value;
      got.fpr_write   = out_ch.fpr_write;
      got.fpr_index   = out_ch.fpr_index;
      got.fpr_data    = out_ch.fpr_data;
      got.status      = out_ch.status;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", exp_r, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(9))
      0: x[62:0] = 63'd0;                              // signed zero
      1: x[62:52] = 11'h7FF;                           // inf or NaN
      2: x = {x[63], 11'h7FF, 52'd0};                  // infinity
      3: x[62:52] = 11'd0;                             // denormal
      4: x[62:52] = 11'(1023 + $urandom_range(7)) ;    // close magnitudes
      default: ;
    endcase
    return x;
  endfunction

  // Build an instruction that is mostly well formed for its operation
  function automatic instr_item_t rand_instr();
    instr_item_t it;
    logic [31:0] w;
    it.op  = fpsc_pkg::op_t'($urandom_range(7));
    w      = $urandom;
    it.opa = rand_double();
    it.opb = ($urandom_range(3) == 0) ? it.opa : rand_double();
    if ($urandom_range(9) != 0) begin
      case (it.op)
        fpsc_pkg::OP_MCRFS: begin
          w[15:11] = 5'd0; w[17:16] = 2'd0; w[22:21] = 2'd0;
        end
        fpsc_pkg::OP_MFFS, fpsc_pkg::OP_MTFSB0, fpsc_pkg::OP_MTFSB1: w[20:11] = 10'd0;
        fpsc_pkg::OP_MTFSF: begin
          w[25] = 1'b0; w[16] = 1'b0;
        end
        fpsc_pkg::OP_MTFSFI: begin
          w[22:16] = 7'd0; w[11] = 1'b0;
        end
        default: w[22:21] = 2'd0;
      endcase
    end
    it.instr = w;
    return it;
  endfunction

  task automatic push_item(input fpsc_pkg::op_t op, input logic [31:0] w,
                           input logic [63:0] a, input logic [63:0] b);
    instr_item_t it;
    it.op = op; it.instr = w; it.opa = a; it.opb = b;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation, extreme fields and each special case
    push_item(fpsc_pkg::OP_MTFSF,  32'h01FE_0000, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF); // all fields
    push_item(fpsc_pkg::OP_MCRFS,  32'h0000_0000, 64'd0, 64'd0); // field 0 clears FX,OX
    push_item(fpsc_pkg::OP_MCRFS,  32'h0384_0000, 64'd0, 64'd0); // cr 7 from field 1
    push_item(fpsc_pkg::OP_MCRFS,  32'h0018_0000, 64'd0, 64'd0); // source field 6
    push_item(fpsc_pkg::OP_MCRFS,  32'h001C_0000, 64'd0, 64'd0); // source field 7
    push_item(fpsc_pkg::OP_MCRFS,  32'h0000_0800, 64'd0, 64'd0); // illegal rb
    push_item(fpsc_pkg::OP_MFFS,   32'h03E0_0001, 64'd0, 64'd0); // mffs to r31 with Rc
    push_item(fpsc_pkg::OP_MFFS,   32'h0001_0000, 64'd0, 64'd0); // illegal ra
    push_item(fpsc_pkg::OP_MTFSB0, 32'h0000_0000, 64'd0, 64'd0); // clear bit 31
    push_item(fpsc_pkg::OP_MTFSB1, 32'h03E0_0001, 64'd0, 64'd0); // set bit 0, Rc
    push_item(fpsc_pkg::OP_MTFSB1, 32'h0000_F800, 64'd0, 64'd0); // illegal rb
    push_item(fpsc_pkg::OP_MTFSF,  32'h0201_0000, 64'd0, 64'd0); // illegal reserved bits
    push_item(fpsc_pkg::OP_MTFSFI, 32'h0380_F001, 64'd0, 64'd0); // field 7 = F, Rc
    push_item(fpsc_pkg::OP_MTFSFI, 32'h0000_0800, 64'd0, 64'd0); // illegal bit 11
    push_item(fpsc_pkg::OP_FCMPU,  32'h0000_0000, 64'h0, 64'h8000_0000_0000_0000); // +0 vs -0
    push_item(fpsc_pkg::OP_FCMPU,  32'h0380_0000,
              64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_item(fpsc_pkg::OP_FCMPU,  32'h0100_0000,
              64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
    push_item(fpsc_pkg::OP_FCMPU,  32'h0080_0000, 64'h7FF8_0000_0000_0000, 64'h0); // NaN, UN
    push_item(fpsc_pkg::OP_FCMPO,  32'h0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF); // NaN, trap
    push_item(fpsc_pkg::OP_FCMPO,  32'h0300_0000,
              64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    push_item(fpsc_pkg::OP_FCMPO,  32'h0020_0000, 64'h0, 64'h0);                   // illegal rd
    drain();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 33 : 0;
      if (ph == 0) long_stall_req = 1'b1;   // long stall so the input backs up
      for (int n = 0; n < 500; n++) pending_q.push_back(rand_instr());
      drain();   // sender pauses until everything has come back
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[fp_status_control_unit.f]
+incdir+src
src/fpsc_pkg.sv
src/fpsc_in_if.sv
src/fpsc_out_if.sv
src/fpsc_compare.sv
src/fp_status_control_unit.sv
verif/fp_status_control_unit_tb.sv
